>>> rtl/crcb_pkg.sv
// ----------------------------------------------------------------------------
// crcb_pkg
// Shared types and constants for the configurable byte-wise CRC.
// ----------------------------------------------------------------------------
package crcb_pkg;

  localparam int unsigned CRC_MAX_BITS_DEF = 32;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CRC_OUT_W        = 32;
  localparam int unsigned NBYTES_W         = 3;

  localparam logic [NBYTES_W-1:0]   RST_CRC_BYTES   = 3'd2;
  localparam logic [CFG_DATA_W-1:0] RST_POLYNOMIAL  = 32'h0000_1021;
  localparam logic [CFG_DATA_W-1:0] RST_INIT_VALUE  = 32'h0000_FFFF;
  localparam logic [CFG_DATA_W-1:0] RST_XOR_OUT     = 32'h0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRC_BYTES   = 3'd0,
    CFG_POLYNOMIAL  = 3'd1,
    CFG_INIT_VALUE  = 3'd2,
    CFG_XOR_OUT     = 3'd3,
    CFG_REFLECT_IN  = 3'd4,
    CFG_REFLECT_OUT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] polynomial;
    logic [CFG_DATA_W-1:0] init_value;
    logic [CFG_DATA_W-1:0] xor_out;
    logic                  reflect_in;
    logic                  reflect_out;
  } crcb_cfg_t;

  function automatic logic [BYTE_W-1:0] mirror_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

endpackage

>>> rtl/configurable_crc_bytewise.sv
// ----------------------------------------------------------------------------
// configurable_crc_bytewise
// Generic CRC of 8 to 32 bits, one message byte per beat.
//
// Input beats carry one byte and a last flag; a message is any run of beats
// ending with last set. Each last beat yields one output beat holding the
// finished CRC (reflected if requested, xored, masked to the width).
// Beats are registered at the input, the byte update and finishing logic
// sit between that register and the remainder/output registers. out_valid
// rises when a last beat moves into the output register; one byte is taken
// every cycle unless stalled. A stalled receiver holds the output register;
// the input register still drains non-last bytes, and in_ready drops only
// once a last beat is waiting behind a full output register.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while the
// block is idle; new init values apply from the next message, new widths at
// once. Synchronous reset loads the default CRC-16 settings (poly 0x1021,
// init 0xFFFF, no reflection, no final xor) and empties both registers.
// ----------------------------------------------------------------------------
module configurable_crc_bytewise
  import crcb_pkg::*;
#(
  parameter int unsigned MAX_CRC_BITS = CRC_MAX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      in_data_byte,
  input  logic                   in_last_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CRC_OUT_W-1:0]   out_crc_value,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned SH_W    = $clog2(MAX_CRC_BITS + 1);
  localparam int unsigned LIM_RAW = MAX_CRC_BITS / BYTE_W;
  localparam int unsigned LIM     = (LIM_RAW < 1) ? 1 : ((LIM_RAW > 4) ? 4 : LIM_RAW);
  localparam logic [NBYTES_W-1:0] LIM_BYTES = NBYTES_W'(LIM);

  logic [NBYTES_W-1:0]      crc_bytes_r;
  crcb_cfg_t                cfg_r;

  logic                     s1_valid_r;
  logic [BYTE_W-1:0]        s1_byte_r;
  logic                     s1_last_r;

  logic [MAX_CRC_BITS-1:0]  rem_r;
  logic                     in_msg_r;
  logic                     out_valid_r;
  logic [CRC_OUT_W-1:0]     out_crc_r;

  logic [NBYTES_W-1:0]      eff_bytes;
  logic [SH_W-1:0]          width_bits;
  logic [SH_W-1:0]          align_sh;
  logic [MAX_CRC_BITS-1:0]  width_mask;
  logic [MAX_CRC_BITS-1:0]  reg_aligned;
  logic [CRC_OUT_W-1:0]     crc_final;
  logic                     out_free;
  logic                     s1_fire;
  logic                     in_fire;

  always_comb begin
    if (crc_bytes_r == '0) begin
      eff_bytes = NBYTES_W'(1);
    end else if (crc_bytes_r > LIM_BYTES) begin
      eff_bytes = LIM_BYTES;
    end else begin
      eff_bytes = crc_bytes_r;
    end
    width_bits = SH_W'({eff_bytes, 3'b000});
    align_sh   = SH_W'(MAX_CRC_BITS) - width_bits;
    width_mask = {MAX_CRC_BITS{1'b1}} >> align_sh;
  end

  assign out_free  = !out_valid_r || out_ready;
  assign s1_fire   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_crc_value = out_crc_r;

  crcb_update #(
    .CRC_W (MAX_CRC_BITS),
    .SH_W  (SH_W)
  ) u_update (
    .cfg         (cfg_r),
    .align_sh    (align_sh),
    .width_mask  (width_mask),
    .rem_in      (rem_r),
    .in_message  (in_msg_r),
    .data_byte   (s1_byte_r),
    .reg_aligned (reg_aligned)
  );

  crcb_finish #(
    .CRC_W (MAX_CRC_BITS),
    .SH_W  (SH_W)
  ) u_finish (
    .cfg         (cfg_r),
    .align_sh    (align_sh),
    .width_mask  (width_mask),
    .reg_aligned (reg_aligned),
    .crc_value   (crc_final)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_bytes_r       <= RST_CRC_BYTES;
      cfg_r.polynomial  <= RST_POLYNOMIAL;
      cfg_r.init_value  <= RST_INIT_VALUE;
      cfg_r.xor_out     <= RST_XOR_OUT;
      cfg_r.reflect_in  <= 1'b0;
      cfg_r.reflect_out <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_BYTES:   crc_bytes_r       <= cfg_wdata[NBYTES_W-1:0];
        CFG_POLYNOMIAL:  cfg_r.polynomial  <= cfg_wdata;
        CFG_INIT_VALUE:  cfg_r.init_value  <= cfg_wdata;
        CFG_XOR_OUT:     cfg_r.xor_out     <= cfg_wdata;
        CFG_REFLECT_IN:  cfg_r.reflect_in  <= cfg_wdata[0];
        CFG_REFLECT_OUT: cfg_r.reflect_out <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        in_msg_r <= !s1_last_r;
      end
      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_fire) begin
      rem_r <= reg_aligned >> align_sh;
    end
    if (s1_fire && s1_last_r) begin
      out_crc_r <= crc_final;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid_r)
    else $error("last byte left no result");

  a_last_ends_message: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> !in_msg_r)
    else $error("message still open after last byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_crc_r)))
    else $error("pending result overwritten");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty stage");

endmodule

>>> rtl/crcb_update.sv
// ----------------------------------------------------------------------------
// crcb_update
// One-byte CRC remainder update, MSB first, on a left-aligned register.
// ----------------------------------------------------------------------------
module crcb_update
  import crcb_pkg::*;
#(
  parameter int unsigned CRC_W = CRC_MAX_BITS_DEF,
  parameter int unsigned SH_W  = $clog2(CRC_W + 1)
) (
  input  crcb_cfg_t          cfg,
  input  logic [SH_W-1:0]    align_sh,
  input  logic [CRC_W-1:0]   width_mask,
  input  logic [CRC_W-1:0]   rem_in,
  input  logic               in_message,
  input  logic [BYTE_W-1:0]  data_byte,
  output logic [CRC_W-1:0]   reg_aligned
);

  logic [CRC_W-1:0]  rem_src;
  logic [CRC_W-1:0]  poly_al;
  logic [BYTE_W-1:0] byte_in;
  logic [CRC_W-1:0]  work;

  always_comb begin
    rem_src = in_message ? rem_in : (cfg.init_value[CRC_W-1:0] & width_mask);
    poly_al = cfg.polynomial[CRC_W-1:0] << align_sh;
    byte_in = cfg.reflect_in ? mirror_byte(data_byte) : data_byte;
    work    = (rem_src & width_mask) << align_sh;
    work[CRC_W-1 -: BYTE_W] = work[CRC_W-1 -: BYTE_W] ^ byte_in;
    for (int i = 0; i < BYTE_W; i++) begin
      if (work[CRC_W-1]) begin
        work = (work << 1) ^ poly_al;
      end else begin
        work = work << 1;
      end
    end
    reg_aligned = work;
  end

endmodule

>>> rtl/crcb_finish.sv
// ----------------------------------------------------------------------------
// crcb_finish
// Final CRC: optional output reflection, final xor and width mask.
// ----------------------------------------------------------------------------
module crcb_finish
  import crcb_pkg::*;
#(
  parameter int unsigned CRC_W = CRC_MAX_BITS_DEF,
  parameter int unsigned SH_W  = $clog2(CRC_W + 1)
) (
  input  crcb_cfg_t              cfg,
  input  logic [SH_W-1:0]        align_sh,
  input  logic [CRC_W-1:0]       width_mask,
  input  logic [CRC_W-1:0]       reg_aligned,
  output logic [CRC_OUT_W-1:0]   crc_value
);

  logic [CRC_W-1:0] reversed;
  logic [CRC_W-1:0] plain;
  logic [CRC_W-1:0] sel;

  always_comb begin
    // reversing the left-aligned register mirrors over the active width
    for (int i = 0; i < CRC_W; i++) begin
      reversed[i] = reg_aligned[CRC_W-1-i];
    end
    plain     = reg_aligned >> align_sh;
    sel       = cfg.reflect_out ? reversed : plain;
    crc_value = CRC_OUT_W'((sel ^ cfg.xor_out[CRC_W-1:0]) & width_mask);
  end

endmodule

>>> tb/tb_configurable_crc_bytewise.sv
// ----------------------------------------------------------------------------
// tb_configurable_crc_bytewise
// Self-checking bench for the configurable byte-wise CRC.
//
// A driver offers queued byte beats and a monitor checks each CRC beat
// against a shadow CRC engine that is updated on every accepted byte.
// A short directed part hits known CRC-16 and CRC-32 check strings, width
// clamping, masked wide operands and a settings change in mid-message.
// Randomised runs then follow under changing settings and handshake idling,
// one of them with a long receiver stall to back the block up.
// ----------------------------------------------------------------------------
module tb_configurable_crc_bytewise
  import crcb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned RUN_ITEMS   = 163;
  localparam int unsigned RUNS        = 12;
  localparam longint     TIMEOUT_NS  = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } crc_beat_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte  = '0;
  logic                  in_last_byte  = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [CRC_OUT_W-1:0]  out_crc_value;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  crc_beat_t            beat_q[$];
  logic [CRC_OUT_W-1:0] crc_expect_q[$];

  // shadow settings and running remainder
  logic [NBYTES_W-1:0] cfg_nbytes = RST_CRC_BYTES;
  crcb_cfg_t           crc_cfg    = '{RST_POLYNOMIAL, RST_INIT_VALUE, RST_XOR_OUT,
                                      1'b0, 1'b0};
  logic [31:0]         crc_rem    = RST_INIT_VALUE;
  bit                  msg_open   = 1'b0;

  int unsigned send_idle   = 0;
  int unsigned recv_idle   = 0;
  int unsigned msg_rem     = 0;
  int unsigned fail_cnt    = 0;
  bit          pressure_go = 1'b0;
  bit          stall_hold  = 1'b0;

  configurable_crc_bytewise u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_crc_value(out_crc_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] flip_bits(input logic [31:0] v, input int unsigned n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[n-1-i] = v[i];
    return r;
  endfunction

  function automatic int unsigned crc_width();
    int unsigned nb;
    nb = cfg_nbytes;
    if (nb < 1) nb = 1;
    if (nb > 4) nb = 4;
    return nb * 8;
  endfunction

  // advance the shadow remainder by one byte; returns 1 with the CRC on a last byte
  function automatic bit crc_feed(input logic [BYTE_W-1:0] d, input logic last,
                                  output logic [CRC_OUT_W-1:0] crc);
    int unsigned w;
    logic [31:0] mask, top_bit, poly, acc, din;
    w       = crc_width();
    mask    = 32'((64'd1 << w) - 64'd1);
    top_bit = 32'd1 << (w - 1);
    poly    = crc_cfg.polynomial & mask;
    crc     = '0;
    if (!msg_open) begin
      crc_rem  = crc_cfg.init_value & mask;
      msg_open = 1'b1;
    end
    din = {24'd0, d};
    if (crc_cfg.reflect_in) din = flip_bits(din, 8);
    acc = (crc_rem & mask) ^ (din << (w - 8));
    for (int i = 0; i < 8; i++) begin
      if ((acc & top_bit) != 0) acc = ((acc << 1) ^ poly) & mask;
      else acc = (acc << 1) & mask;
    end
    crc_rem = acc;
    if (!last) return 1'b0;
    if (crc_cfg.reflect_out) acc = flip_bits(acc, w);
    crc      = (acc ^ crc_cfg.xor_out) & mask;
    crc_rem  = crc_cfg.init_value & mask;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  function automatic void push_beat(input logic [BYTE_W-1:0] d, input logic last);
    beat_q.push_back('{d, last});
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CRC_BYTES:   cfg_nbytes = val[NBYTES_W-1:0];
      CFG_POLYNOMIAL:  crc_cfg.polynomial = val;
      CFG_INIT_VALUE:  crc_cfg.init_value = val;
      CFG_XOR_OUT:     crc_cfg.xor_out = val;
      CFG_REFLECT_IN:  crc_cfg.reflect_in = val[0];
      CFG_REFLECT_OUT: crc_cfg.reflect_out = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid || crc_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(4) == 0) v[NBYTES_W-1:0] = NBYTES_W'($urandom_range(7));
    else v[NBYTES_W-1:0] = NBYTES_W'($urandom_range(4, 1));
    cfg_write(CFG_CRC_BYTES, v);
    cfg_write(CFG_POLYNOMIAL, pick_word());
    cfg_write(CFG_INIT_VALUE, pick_word());
    cfg_write(CFG_XOR_OUT, pick_word());
    cfg_write(CFG_REFLECT_IN, $urandom());
    cfg_write(CFG_REFLECT_OUT, $urandom());
  endtask

  // messages carry on across runs, so a run may end mid-message
  task automatic queue_random_run(input int unsigned n);
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      if (msg_rem == 0)
        msg_rem = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
      push_beat(BYTE_W'($urandom()), msg_rem == 1);
      msg_rem--;
    end
  endtask

  always @(posedge clk) begin : drive_beats
    crc_beat_t            nxt;
    logic [CRC_OUT_W-1:0] crc;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (crc_feed(in_data_byte, in_last_byte, crc)) crc_expect_q.push_back(crc);
      end
      if (!in_valid || in_ready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = beat_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin : check_crc
    logic [CRC_OUT_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (crc_expect_q.size() == 0) begin
        $error("crc_value: no result expected, got %h", out_crc_value);
        fail_cnt++;
      end else begin
        want = crc_expect_q.pop_front();
        if (out_crc_value !== want) begin
          $error("crc_value: expected %h, got %h", want, out_crc_value);
          fail_cnt++;
        end
      end
    end
  end

  // long receiver stall; sender keeps offering beats meanwhile
  initial begin : hold_off
    wait (pressure_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 27;
    recv_idle = 67;

    // default CRC-16 settings
    @(negedge clk);
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    for (int i = 0; i < 9; i++) push_beat(BYTE_W'(8'h31 + i), i == 8);
    wait_idle();

    // reflected CRC-32, plus a write to an unused index
    cfg_write(CFG_CRC_BYTES, 32'd4);
    cfg_write(CFG_POLYNOMIAL, 32'h04C1_1DB7);
    cfg_write(CFG_INIT_VALUE, 32'hFFFF_FFFF);
    cfg_write(CFG_XOR_OUT, 32'hFFFF_FFFF);
    cfg_write(CFG_REFLECT_IN, 32'd1);
    cfg_write(CFG_REFLECT_OUT, 32'd1);
    cfg_write(IDX_SPARE, 32'hFFFF_FFFF);
    @(negedge clk);
    for (int i = 0; i < 9; i++) push_beat(BYTE_W'(8'h31 + i), i == 8);
    wait_idle();

    // narrow to 8 bits in mid-message, junk in the upper write bits
    @(negedge clk);
    push_beat(8'hA5, 1'b0);
    push_beat(8'h5A, 1'b0);
    wait_idle();
    cfg_write(CFG_CRC_BYTES, 32'hFFFF_FFF9);
    cfg_write(CFG_POLYNOMIAL, 32'hFFFF_FFFF);
    cfg_write(CFG_REFLECT_IN, 32'hFFFF_FFFF);
    cfg_write(CFG_REFLECT_OUT, 32'hFFFF_FFFE);
    @(negedge clk);
    push_beat(8'h3C, 1'b1);
    wait_idle();

    // zero width acts as one byte
    cfg_write(CFG_CRC_BYTES, 32'd0);
    cfg_write(CFG_REFLECT_IN, 32'd0);
    cfg_write(CFG_REFLECT_OUT, 32'd1);
    @(negedge clk);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // oversize width saturates to 32 bits
    cfg_write(CFG_CRC_BYTES, 32'd7);
    cfg_write(CFG_INIT_VALUE, 32'd0);
    cfg_write(CFG_XOR_OUT, 32'd0);
    @(negedge clk);
    push_beat(8'h00, 1'b1);
    wait_idle();

    for (int r = 0; r < RUNS; r++) begin
      random_config();
      if (r < RUNS / 3) begin
        send_idle = 27;
        recv_idle = 67;
      end else if (r < 2 * RUNS / 3) begin
        send_idle = 67;
        recv_idle = 27;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (r == 2 * RUNS / 3) pressure_go = 1'b1;
      queue_random_run(RUN_ITEMS);
      wait_idle();
    end
    queue_random_run(msg_rem);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("configurable_crc_bytewise test passed");
    end else begin
      $display("configurable_crc_bytewise test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("configurable_crc_bytewise test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/crcb_pkg.sv
rtl/crcb_update.sv
rtl/crcb_finish.sv
rtl/configurable_crc_bytewise.sv
tb/tb_configurable_crc_bytewise.sv
